### sv/mp2d_pkg.sv
// Shared constants and types for the streaming 2-D max pooling block.
`default_nettype none

package mp2d_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 8;
  localparam int DEF_DATA_BITS  = 16;

  // Fixed field widths
  localparam int COORD_BITS     = 10;
  localparam int DIM_BITS       = 11;
  localparam int WIN_BITS       = 4;
  localparam int DIM_LIMIT      = 1024;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COL_STEP      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_STEP      = 3'd6;

  // Register values after reset
  localparam logic [DIM_BITS-1:0] RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [DIM_BITS-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
  localparam logic [DIM_BITS-1:0] RST_PLANE_COUNT   = 11'd1;
  localparam logic [WIN_BITS-1:0] RST_WINDOW_WIDTH  = 4'd2;
  localparam logic [WIN_BITS-1:0] RST_WINDOW_HEIGHT = 4'd2;
  localparam logic [WIN_BITS-1:0] RST_COL_STEP      = 4'd2;
  localparam logic [WIN_BITS-1:0] RST_ROW_STEP      = 4'd2;

  // Position and flags that travel with a pixel down the pipeline
  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] plane;
    logic                  last_in_plane;
    logic                  last_of_image;
  } tag_t;

endpackage

`default_nettype wire

### sv/mp2d_pixel_if.sv
// Pixel request channel: valid/ready handshake with one signed pixel.
`default_nettype none

interface mp2d_pixel_if #(
  parameter int DATA_BITS = mp2d_pkg::DEF_DATA_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

### sv/mp2d_result_if.sv
// Result request channel: valid/ready handshake with a pooled value and its position.
`default_nettype none

interface mp2d_result_if #(
  parameter int DATA_BITS = mp2d_pkg::DEF_DATA_BITS
);
  logic                                  valid;
  logic                                  ready;
  logic signed [DATA_BITS-1:0]           pooled_value;
  logic [mp2d_pkg::COORD_BITS-1:0]       out_row;
  logic [mp2d_pkg::COORD_BITS-1:0]       out_col;
  logic [mp2d_pkg::COORD_BITS-1:0]       out_plane;
  logic                                  last_in_plane;
  logic                                  last_of_image;

  modport source (output valid, output pooled_value, output out_row, output out_col,
                  output out_plane, output last_in_plane, output last_of_image,
                  input ready);
  modport sink   (input valid, input pooled_value, input out_row, input out_col,
                  input out_plane, input last_in_plane, input last_of_image,
                  output ready);
endinterface

`default_nettype wire

### sv/max_pooling_2d_stream.sv
// Streaming 2-D max pooling over raster-order feature-map planes.
//
// Channels: pixels (sink) takes one signed pixel per request, row after row,
// plane after plane. results (source) gives one request per window that lies
// wholly inside the plane: the window maximum, its output row, column, plane
// and last-in-plane / last-of-image flags. Most pixels close no window and
// give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 image
// width, 1 image height, 2 plane count, 3/4 window width/height, 5/6 stride
// x/y). A write to a listed register also returns the position to row 0,
// column 0, plane 0. Write only while the block is idle.
// Throughput: one pixel per cycle while the pipeline does not hold (see Stall).
// Pipeline: a closing pixel passes the input register and line-buffer read,
// then the column-maximum history, then the output register, where its result
// becomes valid. Line buffers: one RAM per buffered row, each read once per
// pixel at the current column; only the RAM of the current row slot is written.
// Reset (rst, synchronous): registers take their default values and the
// position returns to the start; line buffers are not cleared.
// Stall: while a result waits, pixels are still taken; the pipeline holds
// only when the next result reaches the output register and it is occupied.
`default_nettype none

module max_pooling_2d_stream #(
  parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int DATA_BITS  = mp2d_pkg::DEF_DATA_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mp2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [mp2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  mp2d_pixel_if.sink                               pixels,
  mp2d_result_if.source                            results
);
  import mp2d_pkg::*;

  localparam int LINE_ROWS = MAX_WINDOW - 1;
  localparam int SLOT_BITS = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int COLW      = $clog2(MAX_WIDTH + 1);
  localparam int CSUM      = COLW + 5;

  // Configuration registers
  logic [DIM_BITS-1:0] image_width, image_height, plane_count;
  logic [WIN_BITS-1:0] window_width, window_height, col_step, row_step;

  // Effective (clamped) settings
  logic [COLW-1:0]     w_eff;
  logic [DIM_BITS-1:0] h_eff, p_eff;
  logic [WIN_BITS-1:0] ww_eff, wh_eff, sx_eff, sy_eff;

  // Position state
  logic [COL_BITS-1:0]   col;
  logic [COORD_BITS-1:0] row, plane;
  logic [SLOT_BITS-1:0]  slot;
  logic [WIN_BITS-1:0]   x_phase, y_phase;
  logic [COORD_BITS-1:0] x_out, y_out;

  logic en, accept, cfg_hit;
  logic row_act, col_act, col_end, row_end, plane_end, row_last, col_last;

  // Pipeline stages
  logic                        s1_valid, s1_emit, s1_row_act;
  logic signed [DATA_BITS-1:0] s1_pixel;
  logic [SLOT_BITS-1:0]        s1_slot;
  tag_t                        s1_tag;
  logic signed [DATA_BITS-1:0] bank_q [LINE_ROWS];
  logic signed [DATA_BITS-1:0] colmax;

  logic                        s2_valid, s2_emit;
  tag_t                        s2_tag;
  logic signed [DATA_BITS-1:0] hist [MAX_WINDOW];
  logic signed [DATA_BITS-1:0] pooled;

  // Clamp register values into their working ranges
  always_comb begin
    if (image_width == '0) w_eff = COLW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = COLW'(MAX_WIDTH);
    else w_eff = COLW'(image_width);

    if (image_height == '0) h_eff = DIM_BITS'(1);
    else if (32'(image_height) > DIM_LIMIT) h_eff = DIM_BITS'(DIM_LIMIT);
    else h_eff = image_height;

    if (plane_count == '0) p_eff = DIM_BITS'(1);
    else if (32'(plane_count) > DIM_LIMIT) p_eff = DIM_BITS'(DIM_LIMIT);
    else p_eff = plane_count;

    if (window_width == '0) ww_eff = WIN_BITS'(1);
    else if (32'(window_width) > MAX_WINDOW) ww_eff = WIN_BITS'(MAX_WINDOW);
    else ww_eff = window_width;

    if (window_height == '0) wh_eff = WIN_BITS'(1);
    else if (32'(window_height) > MAX_WINDOW) wh_eff = WIN_BITS'(MAX_WINDOW);
    else wh_eff = window_height;

    sx_eff = (col_step == '0) ? WIN_BITS'(1) : col_step;
    sy_eff = (row_step == '0) ? WIN_BITS'(1) : row_step;
  end

  // Hold the pipeline only when a result would land on an occupied output
  assign en           = !(results.valid && !results.ready && s2_valid && s2_emit);
  assign pixels.ready = en;
  assign accept       = pixels.valid && en;
  assign cfg_hit      = cfg_we && (cfg_index <= REG_ROW_STEP);

  // Window geometry of the current position
  assign row_act   = ({1'b0, row} + 11'd1) >= 11'(wh_eff);
  assign col_act   = (CSUM'(col) + CSUM'(1)) >= CSUM'(ww_eff);
  assign col_end   = (CSUM'(col) + CSUM'(1)) >= CSUM'(w_eff);
  assign row_end   = ({1'b0, row} + 11'd1) >= h_eff;
  assign plane_end = ({1'b0, plane} + 11'd1) >= p_eff;
  assign row_last  = ({2'b0, row} + 12'(sy_eff)) >= {1'b0, h_eff};
  assign col_last  = (CSUM'(col) + CSUM'(sx_eff)) >= CSUM'(w_eff);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      plane_count   <= RST_PLANE_COUNT;
      window_width  <= RST_WINDOW_WIDTH;
      window_height <= RST_WINDOW_HEIGHT;
      col_step      <= RST_COL_STEP;
      row_step      <= RST_ROW_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_PLANE_COUNT:   plane_count   <= cfg_data;
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_BITS-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_BITS-1:0];
        REG_COL_STEP:      col_step      <= cfg_data[WIN_BITS-1:0];
        REG_ROW_STEP:      row_step      <= cfg_data[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance position counters and the stride phase trackers
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col     <= '0;
      row     <= '0;
      plane   <= '0;
      slot    <= '0;
      x_phase <= '0;
      x_out   <= '0;
      y_phase <= '0;
      y_out   <= '0;
    end else if (accept) begin
      if (col_end) begin
        col     <= '0;
        x_phase <= '0;
        x_out   <= '0;
        if (row_end) begin
          row     <= '0;
          slot    <= '0;
          y_phase <= '0;
          y_out   <= '0;
          plane   <= plane_end ? '0 : plane + COORD_BITS'(1);
        end else begin
          row  <= row + COORD_BITS'(1);
          slot <= (slot == SLOT_BITS'(LINE_ROWS - 1)) ? '0 : slot + SLOT_BITS'(1);
          if (row_act) begin
            if (y_phase + WIN_BITS'(1) == sy_eff) begin
              y_phase <= '0;
              y_out   <= y_out + COORD_BITS'(1);
            end else begin
              y_phase <= y_phase + WIN_BITS'(1);
            end
          end
        end
      end else begin
        col <= col + COL_BITS'(1);
        if (col_act) begin
          if (x_phase + WIN_BITS'(1) == sx_eff) begin
            x_phase <= '0;
            x_out   <= x_out + COORD_BITS'(1);
          end else begin
            x_phase <= x_phase + WIN_BITS'(1);
          end
        end
      end
    end
  end

  // Line buffers: one RAM per buffered row, read old data at the write column
  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    logic [DATA_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept) begin
        bank_q[b] <= mem[col];
        if (slot == SLOT_BITS'(b)) begin
          mem[col] <= pixels.pixel;
        end
      end
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel              <= pixels.pixel;
      s1_slot               <= slot;
      s1_row_act            <= row_act;
      s1_emit               <= row_act && col_act && (x_phase == '0) && (y_phase == '0);
      s1_tag.row            <= y_out;
      s1_tag.col            <= x_out;
      s1_tag.plane          <= plane;
      s1_tag.last_in_plane  <= row_last && col_last;
      s1_tag.last_of_image  <= row_last && col_last && plane_end;
    end
  end

  // Column maximum over the buffered rows that fall inside the window
  always_comb begin
    int d;
    colmax = s1_pixel;
    for (int b = 0; b < LINE_ROWS; b++) begin
      d = (int'(s1_slot) >= b) ? int'(s1_slot) - b : int'(s1_slot) + LINE_ROWS - b;
      if (d == 0) d = LINE_ROWS;
      if (s1_row_act && d < int'(wh_eff) && bank_q[b] > colmax) colmax = bank_q[b];
    end
  end

  // Stage 2: shift the column maximum into the history
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      hist[0] <= colmax;
      for (int k = 1; k < MAX_WINDOW; k++) hist[k] <= hist[k-1];
      s2_emit <= s1_emit;
      s2_tag  <= s1_tag;
    end
  end

  // Window maximum over the newest window_width column maxima
  always_comb begin
    pooled = hist[0];
    for (int k = 1; k < MAX_WINDOW; k++) begin
      if (k < int'(ww_eff) && hist[k] > pooled) pooled = hist[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en && s2_valid && s2_emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_emit) begin
      results.pooled_value  <= pooled;
      results.out_row       <= s2_tag.row;
      results.out_col       <= s2_tag.col;
      results.out_plane     <= s2_tag.plane;
      results.last_in_plane <= s2_tag.last_in_plane;
      results.last_of_image <= s2_tag.last_of_image;
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 2-D max pooling block.
module tb_top;
  import mp2d_pkg::*;

  localparam int LINE_ROWS    = DEF_MAX_WINDOW - 1;
  localparam int STRIDE_LIMIT = (1 << WIN_BITS) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1580;
  localparam int WIDE_ITEMS   = 1040;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  // Index past the end of the register list; a write there changes nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNLISTED = 3'd7;

  typedef logic signed [DEF_DATA_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t                value;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] plane;
    logic                  last_in_plane;
    logic                  last_of_image;
  } window_result_t;

  // Zero acts as one, anything past the limit acts as the limit
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Tracks the pooling state and holds the window maxima still due
  class pool_window_board;
    pixel_t               line_rows [LINE_ROWS*DEF_MAX_WIDTH];
    pixel_t               col_max [DEF_MAX_WINDOW];
    logic [DIM_BITS-1:0]  regs [7];
    int unsigned          pos_row, pos_col, pos_plane;
    window_result_t       due_windows [$];
    int                   failures, pixels_taken, windows_checked;

    function new();
      regs[REG_IMAGE_WIDTH]   = RST_IMAGE_WIDTH;
      regs[REG_IMAGE_HEIGHT]  = RST_IMAGE_HEIGHT;
      regs[REG_PLANE_COUNT]   = RST_PLANE_COUNT;
      regs[REG_WINDOW_WIDTH]  = DIM_BITS'(RST_WINDOW_WIDTH);
      regs[REG_WINDOW_HEIGHT] = DIM_BITS'(RST_WINDOW_HEIGHT);
      regs[REG_COL_STEP]      = DIM_BITS'(RST_COL_STEP);
      regs[REG_ROW_STEP]      = DIM_BITS'(RST_ROW_STEP);
      pos_row = 0;
      pos_col = 0;
      pos_plane = 0;
      failures = 0;
      pixels_taken = 0;
      windows_checked = 0;
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    function int pending();
      return due_windows.size();
    endfunction

    function int unsigned dim(logic [CFG_INDEX_BITS-1:0] idx, int unsigned hi);
      return clamp_dim(regs[idx], hi);
    endfunction

    // Store a register and rewind the position; unlisted indexes do nothing
    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_PLANE_COUNT: begin
          regs[idx] = data;
        end
        REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT, REG_COL_STEP, REG_ROW_STEP: begin
          regs[idx] = DIM_BITS'(data[WIN_BITS-1:0]);
        end
        default: begin
          return;
        end
      endcase
      pos_row = 0;
      pos_col = 0;
      pos_plane = 0;
    endfunction

    function void take_pixel(pixel_t px);
      int unsigned w, h, p, ww, wh, sx, sy, k, orow, ocol;
      pixel_t colmax, v, m;
      bit closes_plane;
      window_result_t want;
      w  = dim(REG_IMAGE_WIDTH, DEF_MAX_WIDTH);
      h  = dim(REG_IMAGE_HEIGHT, DIM_LIMIT);
      p  = dim(REG_PLANE_COUNT, DIM_LIMIT);
      ww = dim(REG_WINDOW_WIDTH, DEF_MAX_WINDOW);
      wh = dim(REG_WINDOW_HEIGHT, DEF_MAX_WINDOW);
      sx = dim(REG_COL_STEP, STRIDE_LIMIT);
      sy = dim(REG_ROW_STEP, STRIDE_LIMIT);
      pixels_taken++;
      // column maximum over the buffered rows above, then store the pixel
      colmax = px;
      if (pos_row + 1 >= wh) begin
        for (k = 1; k < wh; k++) begin
          v = line_rows[((pos_row - k) % LINE_ROWS) * DEF_MAX_WIDTH + pos_col];
          if (v > colmax) colmax = v;
        end
      end
      line_rows[(pos_row % LINE_ROWS) * DEF_MAX_WIDTH + pos_col] = px;
      for (k = DEF_MAX_WINDOW - 1; k > 0; k--) col_max[k] = col_max[k-1];
      col_max[0] = colmax;
      // emit when this pixel closes a window on the stride grid
      if (pos_row + 1 >= wh && pos_col + 1 >= ww &&
          (pos_row + 1 - wh) % sy == 0 && (pos_col + 1 - ww) % sx == 0) begin
        orow = (pos_row + 1 - wh) / sy;
        ocol = (pos_col + 1 - ww) / sx;
        m = col_max[0];
        for (k = 1; k < ww; k++) if (col_max[k] > m) m = col_max[k];
        closes_plane = h >= wh && w >= ww && orow == (h - wh) / sy &&
                       ocol == (w - ww) / sx;
        want.value         = m;
        want.row           = COORD_BITS'(orow);
        want.col           = COORD_BITS'(ocol);
        want.plane         = COORD_BITS'(pos_plane);
        want.last_in_plane = closes_plane;
        want.last_of_image = closes_plane && pos_plane + 1 >= p;
        due_windows.push_back(want);
      end
      // advance column, row and plane
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= h) begin
          pos_row = 0;
          pos_plane++;
          if (pos_plane >= p) pos_plane = 0;
        end
      end
    endfunction

    function void check_window(window_result_t got);
      window_result_t want;
      if (due_windows.size() == 0) begin
        complain($sformatf("result with nothing due: value %0d row %0d col %0d plane %0d",
                           got.value, got.row, got.col, got.plane));
        return;
      end
      want = due_windows.pop_front();
      windows_checked++;
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.plane !== want.plane || got.last_in_plane !== want.last_in_plane ||
          got.last_of_image !== want.last_of_image) begin
        complain($sformatf({"window %0d: expected %0d r%0d c%0d p%0d last %b%b, ",
                            "got %0d r%0d c%0d p%0d last %b%b"}, windows_checked,
                           want.value, want.row, want.col, want.plane,
                           want.last_in_plane, want.last_of_image,
                           got.value, got.row, got.col, got.plane,
                           got.last_in_plane, got.last_of_image));
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mp2d_pixel_if  pix_ch ();
  mp2d_result_if res_ch ();

  pool_window_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  int random_sent;
  int settings_used;

  max_pooling_2d_stream i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: drop ready at random
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) board.take_pixel(pix_ch.pixel);
      if (res_ch.valid && res_ch.ready) begin
        board.check_window(window_result_t'{res_ch.pooled_value, res_ch.out_row,
                                            res_ch.out_col, res_ch.out_plane,
                                            res_ch.last_in_plane, res_ch.last_of_image});
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d windows still due", cycles, board.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Write one register; the caller lowers cfg_we after the last write
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] w, h, p, ww, wh, sx, sy);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PLANE_COUNT, p);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_COL_STEP, sx);
    write_reg(REG_ROW_STEP, sy);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one pixel, with random idle cycles first, and hold until taken
  task automatic send_pixel(input pixel_t v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= v;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every due window, then let the pipeline empty
  task automatic finish_burst();
    pix_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling();
    if (random_sent < RANDOM_ITEMS / 3) begin
      send_idle_pct = 33;
      recv_idle_pct = 61;
    end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 61;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  function automatic pixel_t random_pixel();
    case ($urandom_range(9, 0))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return pixel_t'(int'($urandom_range(8, 0)) - 4);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_small(int unsigned hi);
    case ($urandom_range(9, 0))
      0: return '0;
      1: return CFG_DATA_BITS'($urandom_range(STRIDE_LIMIT, hi + 1));
      2: return {(CFG_DATA_BITS-WIN_BITS)'($urandom_range(127, 1)),
                 WIN_BITS'($urandom_range(hi, 1))};
      default: return CFG_DATA_BITS'($urandom_range(hi, 1));
    endcase
  endfunction

  // Random settings (some registers kept), then one or two images (at most 160 pixels) or a fragment
  task automatic run_random_phase();
    logic [CFG_DATA_BITS-1:0] vals [7];
    int unsigned n;
    case ($urandom_range(9, 0))
      0: vals[REG_IMAGE_WIDTH] = '0;
      1: vals[REG_IMAGE_WIDTH] = CFG_DATA_BITS'($urandom_range(20, 13));
      default: vals[REG_IMAGE_WIDTH] = CFG_DATA_BITS'($urandom_range(8, 1));
    endcase
    vals[REG_IMAGE_HEIGHT] = ($urandom_range(9, 0) == 0) ? '0 :
                             CFG_DATA_BITS'($urandom_range(6, 1));
    case ($urandom_range(9, 0))
      0: vals[REG_PLANE_COUNT] = '0;
      1: vals[REG_PLANE_COUNT] = CFG_DATA_BITS'($urandom_range(2047, 1025));
      default: vals[REG_PLANE_COUNT] = CFG_DATA_BITS'($urandom_range(3, 1));
    endcase
    vals[REG_WINDOW_WIDTH]  = random_small(3);
    vals[REG_WINDOW_HEIGHT] = random_small(3);
    vals[REG_COL_STEP]      = random_small(3);
    vals[REG_ROW_STEP]      = random_small(3);
    for (int i = REG_IMAGE_WIDTH; i <= REG_ROW_STEP; i++) begin
      if ($urandom_range(3, 0) != 0) write_reg(CFG_INDEX_BITS'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
    set_idling();
    n = board.dim(REG_IMAGE_WIDTH, DEF_MAX_WIDTH) * board.dim(REG_IMAGE_HEIGHT, DIM_LIMIT) *
        board.dim(REG_PLANE_COUNT, DIM_LIMIT);
    if ($urandom_range(9, 0) < 7) begin
      n = n * $urandom_range(2, 1);
      if (n > 160) n = 160;
    end else begin
      n = $urandom_range(60, 1);
    end
    repeat (n) begin
      send_pixel(random_pixel());
      random_sent++;
    end
    finish_burst();
  endtask

  initial begin
    pixel_t corner_px [12] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                               16'sh8000, 16'sh0100, 16'sh00FF, 16'shFF00, 16'sh8001,
                               16'sh8000, 16'shFFFE};
    bit wide_done;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    board = new();
    random_sent = 0;
    settings_used = 0;
    wide_done = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 61;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Two 3x2 planes with 2x2 windows at unit stride, then wrap to plane 0
    configure(3, 2, 2, 2, 2, 1, 1);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    send_pixel(16'sh7FFF);
    finish_burst();
    // Unlisted register: position must carry on
    write_reg(REG_UNLISTED, 11'h7FF);
    cfg_we <= 1'b0;
    send_pixel(16'sh0000);
    send_pixel(16'sh7FFE);
    finish_burst();
    // Window taller than the plane, junk in the upper data bits
    write_reg(REG_WINDOW_HEIGHT, 11'h7F3);
    cfg_we <= 1'b0;
    repeat (6) send_pixel(random_pixel());
    finish_burst();
    // All zero registers act as 1: every pixel is its own window
    configure(0, 0, 0, 0, 0, 0, 0);
    send_pixel(16'sh8000);
    send_pixel(16'sh7FFF);
    send_pixel(16'sh5A5A);
    finish_burst();

    // Largest window with the largest strides: one window per plane
    set_idling();
    configure(10, 9, 1, 8, 15, 15, 15);
    repeat (90) begin
      send_pixel(random_pixel());
      random_sent++;
    end
    finish_burst();

    while (random_sent < RANDOM_ITEMS) begin
      if (!wide_done && random_sent >= RANDOM_ITEMS / 3) begin
        // Oversized everything: rows wrap at the width limit
        set_idling();
        configure(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 1, 11'h7FF, 1);
        repeat (WIDE_ITEMS) begin
          set_idling();
          send_pixel(random_pixel());
          random_sent++;
        end
        finish_burst();
        wide_done = 1'b1;
      end else begin
        run_random_phase();
      end
    end

    if (board.pending() != 0) board.complain("windows still due at the end of the run");
    $display("Run covered %0d pixels and %0d pooled windows over %0d register settings,",
             board.pixels_taken, board.windows_checked, settings_used);
    $display("with sender-side, receiver-side and no idling; %0d checks failed.",
             board.failures);
    if (board.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
